@@ rtl/core/bmgo_pkg.sv @@
`timescale 1ns / 1ps

package bmgo_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int OFF_W      = 17;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 10;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    // defaults and limits
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_WIDTH     = 320;
    localparam int DEF_HEIGHT    = 240;
    localparam int HEIGHT_LIMIT  = 1024;

    // request queue between front and back, power of two
    localparam int Q_DEPTH = 2;

    // truncating divide by 5 for magnitudes up to 255: (m * 205) >> 10
    localparam logic [15:0] RECIP5       = 16'd205;
    localparam int          RECIP5_SHIFT = 10;

    // dy saturation
    localparam logic signed [7:0] DY_MAX = 8'sd63;
    localparam logic signed [7:0] DY_MIN = -8'sd64;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } t_pix_req;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_req;

    typedef struct packed {
        logic signed [OFF_W-1:0] offset;
        logic                    last_of_run;
        logic                    end_of_frame;
    } t_result;

    // which results a pixel causes, in emission order
    typedef struct packed {
        logic above;
        logic left;
        logic eof;
    } t_kind;

    typedef struct packed {
        logic [PIX_W-1:0] here;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] prev;
        t_kind            kind;
    } t_req;

    function automatic logic signed [7:0] div5(input logic signed [8:0] d);
        logic [8:0]  mag;
        logic [15:0] prod;
        logic [7:0]  q;
        mag  = d[8] ? 9'(-d) : 9'(d);
        prod = 16'(mag) * RECIP5;
        q    = 8'(prod >> RECIP5_SHIFT);
        return d[8] ? 8'(-q) : q;
    endfunction

    function automatic logic signed [OFF_W-1:0] bump_offset(
        input logic [PIX_W-1:0] here,
        input logic [PIX_W-1:0] right,
        input logic [PIX_W-1:0] below
    );
        logic signed [8:0] dx_diff;
        logic signed [8:0] dy_diff;
        logic signed [7:0] dx;
        logic signed [7:0] dy_full;
        logic signed [6:0] dy;
        dx_diff = $signed(9'(right) - 9'(here));
        dy_diff = $signed(9'(below) - 9'(here));
        dx      = div5(dx_diff);
        dy_full = div5(dy_diff);
        if (dy_full > DY_MAX) begin
            dy = 7'(DY_MAX);
        end else if (dy_full < DY_MIN) begin
            dy = 7'(DY_MIN);
        end else begin
            dy = 7'(dy_full);
        end
        return $signed({{(OFF_W-8){dx[7]}}, dx}) + $signed({dy[6], dy, 9'b0});
    endfunction

endpackage

@@ rtl/core/bmgo_chan_if.sv @@
`timescale 1ns / 1ps

interface bmgo_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/bmgo_front.sv @@
`timescale 1ns / 1ps

module bmgo_front #(
    parameter int MAX_WIDTH = bmgo_pkg::DEF_MAX_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bmgo_chan_if.sink          i_cfg,
    bmgo_chan_if.sink          i_pix,
    output logic               o_q_valid,
    input  logic               i_q_ready,
    output bmgo_pkg::t_req     o_q_data
);
    import bmgo_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RST_W = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;

    logic [CW-1:0]    r_last_col;
    logic [ROW_W-1:0] r_last_row;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_prev;
    logic [PIX_W-1:0] r_line [MAX_WIDTH];
    logic [PIX_W-1:0] r_here;
    logic [PIX_W-1:0] r_right;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pixel;
    logic [PIX_W-1:0] r_s1_prev;
    logic             r_s1_last_col;
    t_kind            r_s1_kind;

    logic             cfg_acc;
    logic             pix_acc;
    logic [31:0]      cfg_w;
    logic [CW-1:0]    n_last_col;
    logic [ROW_W-1:0] n_last_row;
    logic             last_col;
    logic             last_row;
    logic [CW-1:0]    rd_addr;
    t_kind            n_kind;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    assign i_pix.ready = !r_s1_valid || i_q_ready;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // clamp written geometry once, keep only the last index
    always_comb begin
        cfg_w = 32'(i_cfg.payload.data);
        if (cfg_w == 32'd0) begin
            n_last_col = '0;
        end else if (cfg_w > 32'(MAX_WIDTH)) begin
            n_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            n_last_col = CW'(cfg_w - 32'd1);
        end
        if (i_cfg.payload.data == '0) begin
            n_last_row = '0;
        end else if (i_cfg.payload.data > CFG_DATA_W'(HEIGHT_LIMIT)) begin
            n_last_row = ROW_W'(HEIGHT_LIMIT - 1);
        end else begin
            n_last_row = ROW_W'(i_cfg.payload.data - CFG_DATA_W'(1));
        end
    end

    always_comb begin
        last_col     = (r_col == r_last_col);
        last_row     = (r_row == r_last_row);
        rd_addr      = last_col ? '0 : r_col + CW'(1);
        n_kind.above = (r_row != '0);
        n_kind.left  = last_row && (r_col != '0);
        n_kind.eof   = last_row && last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RST_W - 1);
            r_last_row <= ROW_W'(DEF_HEIGHT - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_prev     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (cfg_acc && i_cfg.payload.index == CFG_IDX_WIDTH) begin
                r_last_col <= n_last_col;
            end
            if (cfg_acc && i_cfg.payload.index == CFG_IDX_HEIGHT) begin
                r_last_row <= n_last_row;
            end
            if (cfg_acc && (i_cfg.payload.index == CFG_IDX_WIDTH ||
                            i_cfg.payload.index == CFG_IDX_HEIGHT)) begin
                r_col <= '0;
                r_row <= '0;
            end else if (pix_acc) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (pix_acc) begin
                r_prev     <= i_pix.payload.pixel;
                r_s1_valid <= (n_kind != '0);
            end else if (i_q_ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // line store, one read and one write per pixel; the read prefetches the
    // right neighbor, the previous prefetch becomes the pixel above
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_line[r_col] <= i_pix.payload.pixel;
            r_here        <= r_right;
            r_right       <= (rd_addr == r_col) ? i_pix.payload.pixel : r_line[rd_addr];
            r_s1_pixel    <= i_pix.payload.pixel;
            r_s1_prev     <= r_prev;
            r_s1_last_col <= last_col;
            r_s1_kind     <= n_kind;
        end
    end

    assign o_q_valid      = r_s1_valid;
    assign o_q_data.here  = r_here;
    assign o_q_data.right = r_s1_last_col ? r_here : r_right;
    assign o_q_data.pixel = r_s1_pixel;
    assign o_q_data.prev  = r_s1_prev;
    assign o_q_data.kind  = r_s1_kind;

endmodule

@@ rtl/core/bmgo_queue.sv @@
`timescale 1ns / 1ps

module bmgo_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bmgo_pkg::t_req i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bmgo_pkg::t_req o_pop_data
);
    import bmgo_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_req          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != (PW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

@@ rtl/core/bmgo_back.sv @@
`timescale 1ns / 1ps

module bmgo_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  bmgo_pkg::t_req i_q_data,
    bmgo_chan_if.source    o_res
);
    import bmgo_pkg::*;

    t_kind                   r_mask;
    logic signed [OFF_W-1:0] r_off_above;
    logic signed [OFF_W-1:0] r_off_left;
    logic                    r_out_valid;
    t_result                 r_out;

    t_kind                   n_pick;
    t_kind                   n_rest;
    t_kind                   n_mask;
    logic                    out_free;
    logic                    emit;
    t_result                 n_out;

    always_comb begin
        n_pick = '0;
        priority if (r_mask.above) begin
            n_pick.above = 1'b1;
        end else if (r_mask.left) begin
            n_pick.left = 1'b1;
        end else if (r_mask.eof) begin
            n_pick.eof = 1'b1;
        end else begin
            n_pick = '0;
        end
        n_rest   = t_kind'(r_mask & ~n_pick);
        out_free = !r_out_valid || o_res.ready;
        emit     = out_free && (r_mask != '0);
        n_mask   = emit ? n_rest : r_mask;

        if (n_pick.above) begin
            n_out.offset = r_off_above;
        end else if (n_pick.left) begin
            n_out.offset = r_off_left;
        end else begin
            n_out.offset = '0;
        end
        n_out.last_of_run  = (n_rest == '0);
        n_out.end_of_frame = n_pick.eof;
    end

    assign o_q_ready = (n_mask == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_q_valid && o_q_ready) begin
                r_mask <= i_q_data.kind;
            end else begin
                r_mask <= n_mask;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_valid && o_q_ready) begin
            r_off_above <= bump_offset(i_q_data.here, i_q_data.right, i_q_data.pixel);
            r_off_left  <= bump_offset(i_q_data.prev, i_q_data.pixel, i_q_data.prev);
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

@@ rtl/core/bump_map_gradient_offset_core.sv @@
`timescale 1ns / 1ps
// forward-difference bump map generator
// i_pix: 8-bit grey pixels in raster order, one request per accepted pixel
// i_cfg: register writes, index 0 image width, index 1 image height; a width
//   or height write restarts the frame at column 0, row 0 (line store keeps its data)
// o_res: offset = dx + dy*512 plus last_of_run and end_of_frame flags
// results trail the input by one row: a pixel of row r completes the result
//   for the pixel above it; in the last row the left neighbor's result and,
//   at the last column, the final all-zero result follow on the same pixel
// path: front stage register, request queue, back offset registers, output register
// throughput: one pixel per cycle while o_res is ready; in the last row the output port
//   moves one result per cycle, so a pixel there, with up to three results, is accepted
//   more slowly; first-row pixels cause no result unless the first row is also the last
// reset: geometry returns to 320 x 240, counters clear, nothing is pending;
//   line store contents are unknown until the first row is written
// when o_res stalls the output register holds, the request queue fills and
//   i_pix.ready drops; config is always ready
module bump_map_gradient_offset_core #(
    parameter int MAX_WIDTH = bmgo_pkg::DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmgo_chan_if.sink   i_cfg,
    bmgo_chan_if.sink   i_pix,
    bmgo_chan_if.source o_res
);
    import bmgo_pkg::*;

    // front to queue
    logic q_in_valid;
    logic q_in_ready;
    t_req q_in_data;

    // queue to back
    logic q_out_valid;
    logic q_out_ready;
    t_req q_out_data;

    // front: counters, line store, classifies each pixel into a request
    bmgo_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_pix     (i_pix),
        .o_q_valid (q_in_valid),
        .i_q_ready (q_in_ready),
        .o_q_data  (q_in_data)
    );

    // short queue so each side stalls on its own
    bmgo_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_in_valid),
        .o_push_ready (q_in_ready),
        .i_push_data  (q_in_data),
        .o_pop_valid  (q_out_valid),
        .i_pop_ready  (q_out_ready),
        .o_pop_data   (q_out_data)
    );

    // back: differences, divide by 5, saturation, result sequencing
    bmgo_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_out_valid),
        .o_q_ready (q_out_ready),
        .i_q_data  (q_out_data),
        .o_res     (o_res)
    );

endmodule

@@ rtl/core/bmgo_checker.sv @@
`timescale 1ns / 1ps

module bmgo_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input bmgo_pkg::t_result i_res_payload
);
    import bmgo_pkg::*;

    // nothing left pending after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_payload))
        else $error("stalled result changed");

    // the frame's final result closes its run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_payload.end_of_frame |-> i_res_payload.last_of_run)
        else $error("end of frame not last of run");

    // last pixel has itself as both neighbors
    a_eof_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_payload.end_of_frame |-> i_res_payload.offset == '0)
        else $error("end of frame offset not zero");

endmodule

bind bump_map_gradient_offset_core bmgo_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload)
);

@@ verif/bump_map_gradient_offset_checker.sv @@
`timescale 1ns / 1ps

module bump_map_gradient_offset_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bmgo_chan_if i_cfg,
    bmgo_chan_if i_pix,
    bmgo_chan_if i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_pixel_count,
    output int   o_result_count
);
    import bmgo_pkg::*;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [PIX_W-1:0]      row_mem [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]      last_pixel;
    int unsigned           col;
    int unsigned           row;
    t_result               pending_offsets [$];

    function automatic logic signed [OFF_W-1:0] gradient_offset(
        input int here,
        input int right,
        input int below
    );
        int dx;
        int dy;
        dx = (right - here) / 5;
        dy = (below - here) / 5;
        dx = (dx < -128) ? -128 : (dx > 127) ? 127 : dx;
        dy = (dy < -64) ? -64 : (dy > 63) ? 63 : dy;
        return OFF_W'(dx + dy * 512);
    endfunction

    // results caused by one pixel, appended in emission order
    task automatic predict_offsets(input logic [PIX_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          here;
        int          right;
        int          n;
        t_result     batch [3];
        w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
        c = (col >= w) ? w - 1 : col;
        r = (row >= h) ? h - 1 : row;
        n = 0;
        if (r > 0) begin
            here  = int'(row_mem[c]);
            right = (c == w - 1) ? here : int'(row_mem[c + 1]);
            batch[n] = '{offset: gradient_offset(here, right, int'(pix)),
                         last_of_run: 1'b0, end_of_frame: 1'b0};
            n++;
        end
        if (r == h - 1) begin
            if (c > 0) begin
                batch[n] = '{offset: gradient_offset(int'(last_pixel), int'(pix),
                                                     int'(last_pixel)),
                             last_of_run: 1'b0, end_of_frame: 1'b0};
                n++;
            end
            if (c == w - 1) begin
                batch[n] = '{offset: '0, last_of_run: 1'b0, end_of_frame: 1'b1};
                n++;
            end
        end
        if (n > 0) begin
            batch[n - 1].last_of_run = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            pending_offsets.push_back(batch[k]);
        end
        row_mem[c] = pix;
        last_pixel = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) begin
                r = 0;
            end
        end
        col = c;
        row = r;
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_offsets.size() == 0) begin
            $error("result with nothing pending: offset %0d last_of_run %0b end_of_frame %0b",
                   got.offset, got.last_of_run, got.end_of_frame);
            o_fail_count++;
        end else begin
            want = pending_offsets.pop_front();
            if (got.offset !== want.offset) begin
                $error("offset mismatch: expected %0d, actual %0d", want.offset, got.offset);
                o_fail_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run mismatch: expected %0b, actual %0b",
                       want.last_of_run, got.last_of_run);
                o_fail_count++;
            end
            if (got.end_of_frame !== want.end_of_frame) begin
                $error("end_of_frame mismatch: expected %0b, actual %0b",
                       want.end_of_frame, got.end_of_frame);
                o_fail_count++;
            end
        end
        o_result_count++;
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_pixel_count  = 0;
        o_result_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = 11'(DEF_WIDTH);
            height_reg = 11'(DEF_HEIGHT);
            last_pixel = '0;
            col        = 0;
            row        = 0;
            pending_offsets.delete();
        end else begin
            // compare first: a result never leaves on the edge its pixel enters
            if (i_res.valid && i_res.ready) begin
                check_result(i_res.payload);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.payload.index)
                    CFG_IDX_WIDTH: begin
                        width_reg = i_cfg.payload.data;
                        col = 0;
                        row = 0;
                    end
                    CFG_IDX_HEIGHT: begin
                        height_reg = i_cfg.payload.data;
                        col = 0;
                        row = 0;
                    end
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                predict_offsets(i_pix.payload.pixel);
                o_pixel_count++;
            end
        end
        o_pending = pending_offsets.size();
    end

endmodule

@@ verif/bump_map_gradient_offset_core_tb.sv @@
`timescale 1ns / 1ps

module bump_map_gradient_offset_core_tb;
    import bmgo_pkg::*;

    // indexes outside the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    localparam int RANDOM_PIXELS = 120;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bmgo_chan_if #(.T(t_cfg_req)) cfg_ch ();
    bmgo_chan_if #(.T(t_pix_req)) pix_ch ();
    bmgo_chan_if #(.T(t_result))  res_ch ();

    int fail_count;
    int pending_count;
    int pixel_count;
    int result_count;

    // idling knobs, changed only on a rising edge
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_active  = 1'b0;
    event hold_kick;

    int geometry_count = 0;
    logic [PIX_W-1:0] prev_pix = '0;

    bump_map_gradient_offset_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    bump_map_gradient_offset_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg_ch),
        .i_pix          (pix_ch),
        .i_res          (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_pixel_count  (pixel_count),
        .o_result_count (result_count)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result sink: random stalls, or a long hold-off while hold_active is up
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long hold-off on the result side, counted here on rising edges
    initial begin
        forever begin
            @(hold_kick);
            @(posedge i_clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
        end
    end

    // watchdog
    initial begin
        #200000;
        $display("bump_map_gradient_offset_core test failed");
        $finish;
    end

    // one register write; called and returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid   = 1'b1;
        cfg_ch.payload = '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // one pixel request; valid stays up into the next request unless idling
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid   = 1'b1;
        pix_ch.payload = '{pixel: pix};
        do @(posedge i_clk); while (!pix_ch.ready);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every expected result, then let the pipe empty
    // (row-0 pixels cause no result but may still be in flight)
    task automatic settle();
        pix_ch.valid = 1'b0;
        wait (pending_count == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] h);
        settle();
        write_reg(CFG_IDX_WIDTH, w);
        write_reg(CFG_IDX_HEIGHT, h);
        geometry_count++;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        @(negedge i_clk);
    endtask

    // mix of fresh values and small steps, so truncation near zero is hit
    function automatic logic [PIX_W-1:0] next_pixel();
        int v;
        if ($urandom_range(2) == 0) begin
            v = $urandom_range(255);
        end else begin
            v = int'(prev_pix) + int'($urandom_range(14)) - 7;
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
        end
        prev_pix = PIX_W'(v);
        return prev_pix;
    endfunction

    initial begin
        int phase;
        int random_pixels;
        int n;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;

        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        pix_ch.valid   = 1'b0;
        pix_ch.payload = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: 3x2 frame with full-swing steps, last column and last row
        set_geometry(11'd3, 11'd2);
        send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd7);
        send_pixel(8'd255); send_pixel(8'd0);   send_pixel(8'd1);

        // width 0 acts as 1: two one-column frames of two rows
        set_geometry(11'd0, 11'd2);
        send_pixel(8'd255); send_pixel(8'd0); send_pixel(8'd0); send_pixel(8'd255);

        // width beyond the line store, single-row frame
        set_geometry(11'd2047, 11'd1);
        send_pixel(8'd0); send_pixel(8'd128); send_pixel(8'd255);

        // height 0 acts as 1
        set_geometry(11'd2, 11'd0);
        send_pixel(8'd200); send_pixel(8'd3); send_pixel(8'd9);

        // tall frame; writes to spare indexes mid-frame must not restart it
        set_geometry(11'd4, 11'd2047);
        send_pixel(8'd10); send_pixel(8'd250);
        settle();
        write_reg(CFG_IDX_SPARE2, 11'h7ff);
        write_reg(CFG_IDX_SPARE3, 11'h000);
        send_pixel(8'd40);  send_pixel(8'd33); send_pixel(8'd128);
        send_pixel(8'd255); send_pixel(8'd0);  send_pixel(8'd77);

        // random phases cycling through the idling modes
        phase = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            if (phase == 2) begin
                // small frame with results on most rows for the hold-off
                w = 11'd3;
                h = 11'd4;
                n = 24;
            end else if ($urandom_range(5) == 0) begin
                // extreme geometry, kept to a short partial run
                if ($urandom_range(1) == 1) begin
                    w = $urandom_range(1) ? 11'd1024 : 11'd2047;
                    h = $urandom_range(1) ? 11'd1 : 11'd0;
                end else begin
                    w = $urandom_range(1) ? 11'd1 : 11'd0;
                    h = $urandom_range(1) ? 11'd1024 : 11'd2047;
                end
                n = 12;
            end else begin
                w = 11'($urandom_range(1, 8));
                h = 11'($urandom_range(1, 5));
                n = int'(w) * int'(h) * int'($urandom_range(1, 2));
                // sometimes stop mid-frame and let the next write restart it
                if ($urandom_range(3) == 0) begin
                    n += $urandom_range(1, int'(w));
                end
            end
            set_geometry(w, h);
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(45, 0);
                2: set_idling(0, 45);
                default: set_idling(36, 36);
            endcase
            if (phase == 2) begin
                -> hold_kick;
            end
            for (int k = 0; k < n; k++) begin
                send_pixel(next_pixel());
                random_pixels++;
            end
            phase++;
        end

        settle();
        $display("run covered %0d pixel requests and %0d results over %0d geometries",
                 pixel_count, result_count, geometry_count);
        $display("including out-of-range sizes, spare register writes and a long output stall");
        if (fail_count == 0 && pending_count == 0) begin
            $display("bump_map_gradient_offset_core test passed");
        end else begin
            $display("bump_map_gradient_offset_core test failed");
        end
        $finish;
    end

endmodule
